FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, muted while reset is asserted.
`define PFB_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PFB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pfb_pkg.sv
package pfb_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MASK_MODE = 2'd2;

  typedef enum logic [1:0] {
    OP_BLIT  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } pfb_op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MOD0,
    S_MOD1,
    S_DONE
  } pfb_state_t;

  typedef struct packed {
    logic do0;
    logic do1;
    logic clip;
  } pfb_place_t;

  function automatic logic [7:0] pfb_merge(input logic [7:0] old_byte,
                                           input logic [7:0] bits,
                                           input logic [7:0] keep,
                                           input logic       mask_mode);
    logic [7:0] res;
    if (mask_mode) begin
      res = old_byte & (bits | keep);
    end else begin
      res = old_byte | bits;
    end
    return res;
  endfunction

endpackage

FILE: rtl/pfb_ram.sv
module pfb_ram import pfb_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/pfb_place.sv
module pfb_place import pfb_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  pfb_op_t                             op,
  input  logic [6:0]                          column,
  input  logic [2:0]                          page,
  input  logic [7:0]                          origin_x,
  input  logic [5:0]                          origin_y,
  output logic [$clog2(COLUMNS*PAGES)-1:0]    addr0,
  output logic [$clog2(COLUMNS*PAGES)-1:0]    addr1,
  output pfb_place_t                          place
);

  localparam int AW = $clog2(COLUMNS * PAGES);
  localparam logic [AW-1:0] ROW_STEP = AW'(COLUMNS);

  logic [8:0] x;
  logic [4:0] p;
  logic [4:0] p1;
  logic       shifted;
  logic       x_ok;
  logic       p_ok;
  logic       p1_ok;
  logic       col_ok;
  logic       pg_ok;
  logic [4:0] row_sel;
  logic [8:0] col_sel;

  always_comb begin
    x       = {1'b0, origin_x} + 9'(column);
    p       = 5'(origin_y[5:3]) + 5'(page);
    p1      = p + 5'd1;
    shifted = (origin_y[2:0] != 3'd0);
    x_ok    = (x < 9'(COLUMNS));
    p_ok    = (p < 5'(PAGES));
    p1_ok   = (p1 < 5'(PAGES));
    col_ok  = (9'(column) < 9'(COLUMNS));
    pg_ok   = (5'(page) < 5'(PAGES));
  end

  always_comb begin
    place = '0;
    case (op)
      OP_BLIT: begin
        place.do0  = x_ok && p_ok;
        place.do1  = x_ok && shifted && p1_ok;
        place.clip = !x_ok || !p_ok || (shifted && !p1_ok);
      end
      OP_WRITE, OP_READ: begin
        place.do0  = col_ok && pg_ok;
        place.clip = !(col_ok && pg_ok);
      end
      default: begin
        place = '0;
      end
    endcase
  end

  assign row_sel = (op == OP_BLIT) ? p : 5'(page);
  assign col_sel = (op == OP_BLIT) ? x : 9'(column);
  assign addr0   = AW'(row_sel) * ROW_STEP + AW'(col_sel);
  assign addr1   = addr0 + ROW_STEP;

endmodule

FILE: rtl/page_framebuffer_sprite_blitter.sv
// A write, an unused code or a blit that lands fully off the frame passes S_READ and then
// S_DONE; a read or a one-byte blit adds S_MOD0, and a two-byte blit adds S_MOD1 too.
// Items are worked one at a time; the next item can be taken in the cycle after the result
// is loaded. A blit reads each byte in the cycle before it writes it back, overlapped.
// Reset: synchronous, active low; a clearing pass then writes zero to all
// COLUMNS*PAGES bytes, one per cycle, and no item is taken until it ends.
module page_framebuffer_sprite_blitter import pfb_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte[7:0], column[14:8], page[17:15]
  input  logic [1:0]             in_tuser,   // operation[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // read_data[7:0], clipped[8]
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  pfb_state_t state_r, state_nxt;
  logic [AW-1:0] clr_addr_r;
  pfb_op_t       op_r;
  logic [7:0]    data_r;
  logic [6:0]    col_r;
  logic [2:0]    pg_r;
  logic [7:0]    rd_byte_r;
  logic [7:0]    origin_x_r;
  logic [5:0]    origin_y_r;
  logic          mask_mode_r;
  logic          out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic [AW-1:0] addr0;
  logic [AW-1:0] addr1;
  pfb_place_t    place;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [15:0]   sprite_wide;
  logic [15:0]   cover_wide;
  logic [7:0]    merged_lo;
  logic [7:0]    merged_hi;
  logic          in_xfer;
  logic          out_free;
  logic          load_out;
  logic          cap_rd;

  pfb_place #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_place (
    .op      (op_r),
    .column  (col_r),
    .page    (pg_r),
    .origin_x(origin_x_r),
    .origin_y(origin_y_r),
    .addr0   (addr0),
    .addr1   (addr1),
    .place   (place)
  );

  pfb_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign sprite_wide = {8'h00, data_r} << origin_y_r[2:0];
  assign cover_wide  = 16'h00ff << origin_y_r[2:0];
  assign merged_lo   = pfb_merge(ram_rdata, sprite_wide[7:0], ~cover_wide[7:0], mask_mode_r);
  assign merged_hi   = pfb_merge(ram_rdata, sprite_wide[15:8], ~cover_wide[15:8], mask_mode_r);

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (place.do0 && (op_r == OP_BLIT || op_r == OP_READ)) begin
          state_nxt = S_MOD0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MOD0: begin
        if (op_r == OP_BLIT && place.do1) begin
          state_nxt = S_MOD1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MOD1: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = addr0;
    ram_wdata = data_r;
    ram_raddr = addr0;
    cap_rd    = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = 8'h00;
      end
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_READ: begin
        ram_we = (op_r == OP_WRITE) && place.do0;
      end
      S_MOD0: begin
        ram_raddr = addr1;
        ram_we    = (op_r == OP_BLIT);
        ram_wdata = merged_lo;
        cap_rd    = (op_r == OP_READ);
      end
      S_MOD1: begin
        ram_we    = 1'b1;
        ram_waddr = addr1;
        ram_wdata = merged_hi;
      end
      S_DONE: begin
        load_out = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      mask_mode_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ORIGIN_X:  origin_x_r  <= cfg_wdata;
          CFG_ORIGIN_Y:  origin_y_r  <= cfg_wdata[5:0];
          CFG_MASK_MODE: mask_mode_r <= cfg_wdata[0];
          default: begin
            origin_x_r <= origin_x_r;
          end
        endcase
      end
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r      <= pfb_op_t'(in_tuser);
      data_r    <= in_tdata[7:0];
      col_r     <= in_tdata[14:8];
      pg_r      <= in_tdata[17:15];
      rd_byte_r <= 8'h00;
    end else if (cap_rd) begin
      rd_byte_r <= ram_rdata;
    end
    if (load_out) begin
      out_tdata_r <= {7'b0, place.clip, rd_byte_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: rtl/pfb_checker.sv
`include "assert_macros.svh"

module pfb_checker import pfb_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result keeps its valid and its payload.
  `PFB_ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // Items are worked one at a time, so a transfer closes the input for the next cycle.
  `PFB_ASSERT_RST(a_one_item, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "input open right after a transfer")

  // A new result appears only while the input was closed for the finishing item.
  `PFB_ASSERT_RST(a_result_origin, clk, rst_n, $rose(out_tvalid) |-> $past(!in_tready), "result appeared while idle")

  // Reset empties the output and starts the clearing pass with the input closed.
  `PFB_ASSERT_ALWAYS(a_reset_state, clk, !rst_n |=> !out_tvalid && !in_tready, "reset did not close the block")

endmodule

bind page_framebuffer_sprite_blitter pfb_checker u_pfb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

FILE: test/page_framebuffer_sprite_blitter_tb.sv
`timescale 1ns / 100ps

module page_framebuffer_sprite_blitter_tb;
  import pfb_pkg::*;

  localparam int COLS = 128;
  localparam int PAGES = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int SEGMENTS = 12;
  localparam int SEG_ITEMS = 96;
  localparam int DIR_ROWS = 31;

  typedef struct packed {
    logic [7:0] rd;
    logic       clip;
  } frame_result_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    pfb_op_t               op;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [7:0]            data;
    logic [6:0]            col;
    logic [2:0]            pg;
    logic                  typed;
    logic [7:0]            want_rd;
    logic                  want_clip;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Expected values typed into the directed table travel alongside the transfer.
  logic       fixed_valid = 1'b0;
  logic [7:0] fixed_rd = 8'h00;
  logic       fixed_clip = 1'b0;

  logic [7:0] fb [COLS*PAGES];
  logic [7:0] org_x = 8'h00;
  logic [5:0] org_y = 6'h00;
  logic       mask_q = 1'b0;

  frame_result_t pending_results [$];
  int send_idle_pct = 9;
  int recv_idle_pct = 54;
  int n_errors = 0;
  int n_items = 0;
  int n_blits = 0;
  int n_clipped = 0;
  int n_reg_writes = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_ITEM, OP_READ,  CFG_ORIGIN_X,  8'h00, 7'd0,   3'd0, 1'b1, 8'h00, 1'b0},
    '{ROW_ITEM, OP_READ,  CFG_ORIGIN_X,  8'h00, 7'd127, 3'd7, 1'b1, 8'h00, 1'b0},
    '{ROW_ITEM, OP_NONE,  CFG_ORIGIN_X,  8'hff, 7'd127, 3'd7, 1'b1, 8'h00, 1'b0},
    '{ROW_ITEM, OP_WRITE, CFG_ORIGIN_X,  8'ha5, 7'd0,   3'd0, 1'b1, 8'h00, 1'b0},
    '{ROW_ITEM, OP_READ,  CFG_ORIGIN_X,  8'h00, 7'd0,   3'd0, 1'b1, 8'ha5, 1'b0},
    '{ROW_ITEM, OP_WRITE, CFG_ORIGIN_X,  8'hff, 7'd127, 3'd7, 1'b1, 8'h00, 1'b0},
    '{ROW_ITEM, OP_READ,  CFG_ORIGIN_X,  8'h00, 7'd127, 3'd7, 1'b1, 8'hff, 1'b0},
    '{ROW_ITEM, OP_BLIT,  CFG_ORIGIN_X,  8'h81, 7'd5,   3'd2, 1'b1, 8'h00, 1'b0},
    '{ROW_ITEM, OP_READ,  CFG_ORIGIN_X,  8'h00, 7'd5,   3'd2, 1'b1, 8'h81, 1'b0},
    '{ROW_ITEM, OP_BLIT,  CFG_ORIGIN_X,  8'h00, 7'd127, 3'd7, 1'b1, 8'h00, 1'b0},
    '{ROW_CFG,  OP_NONE,  CFG_ORIGIN_X,  8'hff, 7'd0,   3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, OP_BLIT,  CFG_ORIGIN_X,  8'hff, 7'd0,   3'd0, 1'b1, 8'h00, 1'b1},
    '{ROW_CFG,  OP_NONE,  CFG_ORIGIN_X,  8'd120, 7'd0,  3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG,  OP_NONE,  CFG_ORIGIN_Y,  8'd3,  7'd0,   3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, OP_BLIT,  CFG_ORIGIN_X,  8'hff, 7'd7,   3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, OP_READ,  CFG_ORIGIN_X,  8'h00, 7'd127, 3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, OP_READ,  CFG_ORIGIN_X,  8'h00, 7'd127, 3'd1, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG,  OP_NONE,  CFG_ORIGIN_Y,  8'd63, 7'd0,   3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, OP_BLIT,  CFG_ORIGIN_X,  8'h00, 7'd0,   3'd0, 1'b1, 8'h00, 1'b1},
    '{ROW_CFG,  OP_NONE,  CFG_MASK_MODE, 8'h01, 7'd0,   3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, OP_BLIT,  CFG_ORIGIN_X,  8'h00, 7'd7,   3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, OP_READ,  CFG_ORIGIN_X,  8'h00, 7'd127, 3'd7, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG,  OP_NONE,  CFG_ORIGIN_Y,  8'd56, 7'd0,   3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, OP_BLIT,  CFG_ORIGIN_X,  8'h55, 7'd0,   3'd1, 1'b1, 8'h00, 1'b1},
    '{ROW_CFG,  OP_NONE,  CFG_ORIGIN_X,  8'h00, 7'd0,   3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG,  OP_NONE,  CFG_ORIGIN_Y,  8'h00, 7'd0,   3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, OP_BLIT,  CFG_ORIGIN_X,  8'h0f, 7'd0,   3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, OP_READ,  CFG_ORIGIN_X,  8'h00, 7'd0,   3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG,  OP_NONE,  CFG_MASK_MODE, 8'h00, 7'd0,   3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, OP_BLIT,  CFG_ORIGIN_X,  8'hf0, 7'd0,   3'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, OP_READ,  CFG_ORIGIN_X,  8'h00, 7'd0,   3'd0, 1'b0, 8'h00, 1'b0}
  };

  page_framebuffer_sprite_blitter #(
    .COLUMNS(COLS),
    .PAGES  (PAGES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // data_byte[7:0], column[14:8], page[17:15]
    .in_tuser  (in_tuser),   // operation[1:0]
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // read_data[7:0], clipped[8]
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic logic frame_merge(input int x, input int pg, input logic [7:0] bits,
                                       input logic [7:0] keep);
    int a;
    if (x >= COLS || pg >= PAGES) return 1'b1;
    a = x + pg * COLS;
    if (mask_q) fb[a] = fb[a] & (bits | keep);
    else fb[a] = fb[a] | bits;
    return 1'b0;
  endfunction

  function automatic frame_result_t frame_apply(input pfb_op_t op, input logic [7:0] d,
                                                input logic [6:0] c, input logic [2:0] p);
    frame_result_t res;
    int x;
    int pp;
    logic [2:0] sh;
    logic [15:0] spread;
    logic [7:0] hikeep;
    res = '0;
    case (op)
      OP_BLIT: begin
        x = int'(org_x) + int'(c);
        sh = org_y[2:0];
        pp = int'(org_y[5:3]) + int'(p);
        spread = {8'h00, d} << sh;
        hikeep = 8'hff << sh;
        if (x >= COLS) begin
          res.clip = 1'b1;
        end else begin
          res.clip = frame_merge(x, pp, spread[7:0], ~hikeep);
          if (sh != 3'd0) res.clip |= frame_merge(x, pp + 1, spread[15:8], hikeep);
        end
      end
      OP_WRITE: fb[int'(c) + int'(p) * COLS] = d;
      OP_READ: res.rd = fb[int'(c) + int'(p) * COLS];
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : scoreboard
    frame_result_t want;
    frame_result_t got;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ORIGIN_X: org_x = cfg_wdata;
          CFG_ORIGIN_Y: org_y = cfg_wdata[5:0];
          CFG_MASK_MODE: mask_q = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = frame_apply(pfb_op_t'(in_tuser), in_tdata[7:0], in_tdata[14:8],
                           in_tdata[17:15]);
        if (fixed_valid) want = {fixed_rd, fixed_clip};
        pending_results.push_back(want);
        n_items++;
        if (pfb_op_t'(in_tuser) == OP_BLIT) n_blits++;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[7:0], out_tdata[8]};
        if (got.clip) n_clipped++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transfer, read_data %02h clipped %0b",
                   $time, got.rd, got.clip);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.rd !== want.rd) begin
            $display("%0t: read_data expected %02h, got %02h", $time, want.rd, got.rd);
            n_errors++;
          end
          if (got.clip !== want.clip) begin
            $display("%0t: clipped expected %0b, got %0b", $time, want.clip, got.clip);
            n_errors++;
          end
        end
      end
    end
  end

  task automatic settle_frame();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    settle_frame();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_reg_writes++;
  endtask

  task automatic send_item(input pfb_op_t op, input logic [7:0] d, input logic [6:0] c,
                           input logic [2:0] p, input logic typed, input logic [7:0] trd,
                           input logic tclip);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'b000000, p, c, d};
    fixed_valid <= typed;
    fixed_rd <= trd;
    fixed_clip <= tclip;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin : stimulus
    int seg;
    int k;
    int roll;
    logic [7:0] ox;
    logic [5:0] oy;
    logic m;
    logic [7:0] d;
    logic [6:0] c;
    logic [2:0] p;
    pfb_op_t op;
    foreach (fb[i]) fb[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // The block clears its store after reset before it takes any transfer.
    for (k = 0; k < COLS * PAGES + 64 && !in_tready; k++) @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].reg_idx, dir_tab[i].data);
      end else begin
        send_item(dir_tab[i].op, dir_tab[i].data, dir_tab[i].col, dir_tab[i].pg,
                  dir_tab[i].typed, dir_tab[i].want_rd, dir_tab[i].want_clip);
      end
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin ox = 8'd0; oy = 6'd0; m = 1'b0; end
        1: begin ox = 8'd255; oy = 6'd63; m = 1'b1; end
        2: begin ox = 8'd3; oy = 6'd5; m = 1'b0; end
        3: begin ox = 8'd0; oy = 6'd63; m = 1'b0; end
        4: begin ox = 8'd127; oy = 6'd7; m = 1'b1; end
        default: begin
          ox = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
          oy = 6'($urandom);
          m = 1'($urandom);
        end
      endcase
      if (seg < 4) begin
        send_idle_pct = 9;
        recv_idle_pct = 54;
      end else if (seg < 8) begin
        send_idle_pct = 54;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_ORIGIN_X, ox);
      write_reg(CFG_ORIGIN_Y, {2'b00, oy});
      write_reg(CFG_MASK_MODE, {7'b0000000, m});

      for (k = 0; k < SEG_ITEMS; k++) begin
        if ($urandom_range(0, 63) == 0) settle_frame();
        roll = $urandom_range(0, 99);
        op = (roll < 40) ? OP_BLIT : (roll < 55) ? OP_WRITE : (roll < 90) ? OP_READ : OP_NONE;
        roll = $urandom_range(0, 9);
        d = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hff : 8'($urandom);
        p = 3'($urandom);
        c = 7'($urandom);
        // Keep half the traffic on a narrow strip so reads see what blits drew.
        if ($urandom_range(0, 1) == 1) begin
          if (op != OP_BLIT) c = 7'($urandom_range(0, 15));
          else if (ox < 8'd16) c = 7'($urandom_range(0, 15 - int'(ox)));
        end
        send_item(op, d, c, p, 1'b0, 8'h00, 1'b0);
      end
    end

    settle_frame();
    $display("Covered %0d transfers, %0d of them blits, %0d clipped results, %0d register writes.",
             n_items, n_blits, n_clipped, n_reg_writes);
    $display("Traffic ran with a stalling receiver, then a slow sender, then back to back.");
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
